// File: rtl/hepc_pkg.sv
// shared constants and field widths for the ham / half-brite pixel colour block
package hepc_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
  localparam int PIX_W         = 6;
  localparam int IDX_W         = 5;
  localparam int WORD_W        = 12;
  localparam int NIB_W         = 4;
  localparam int CH_W          = 8;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  localparam logic OP_PAL_WRITE = 1'b0;
  localparam logic OP_PIXEL     = 1'b1;

  localparam logic REG_HAM_MODE  = 1'b0;
  localparam logic REG_TRANS_ZERO = 1'b1;

  localparam logic [1:0] HAM_BASE  = 2'd0;
  localparam logic [1:0] HAM_BLUE  = 2'd1;
  localparam logic [1:0] HAM_RED   = 2'd2;
  localparam logic [1:0] HAM_GREEN = 2'd3;

  typedef logic [NIB_W-1:0] nib_t;
  typedef logic [CH_W-1:0]  chan_t;

  function automatic chan_t widen(input nib_t n);
    widen = {n, n};
  endfunction

endpackage

// File: rtl/hepc_if.sv
// valid / ready channel interfaces for pixel input and colour output
interface hepc_in_if;
  import hepc_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic              line_start;
  logic [PIX_W-1:0]  pixel_value;
  logic [IDX_W-1:0]  palette_index;
  logic [WORD_W-1:0] palette_word;

  modport source (output valid, op, line_start, pixel_value, palette_index, palette_word,
                  input ready);
  modport sink   (input valid, op, line_start, pixel_value, palette_index, palette_word,
                  output ready);
endinterface

interface hepc_out_if;
  import hepc_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic            is_transparent;

  modport source (output valid, red, green, blue, is_transparent, input ready);
  modport sink   (input valid, red, green, blue, is_transparent, output ready);
endinterface

// File: rtl/hepc_ram.sv
// generic single-write, single-read ram with registered read data
module hepc_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/ham_ehb_pixel_colour.sv
// top level: palette, ham / half-brite decode and output register
//
// in_if carries palette writes (op 0) and pixels (op 1) with valid / ready.
// a palette write updates one entry and produces nothing on out_if.
// a pixel produces one colour transfer on out_if after it is taken:
// first the palette ram read, then decode into the output register.
// one item is taken per cycle unless out_if stalls; the palette ram read
// port and the held-colour register step set that rate.
// the apb port (psel, penable, pwrite, paddr, pwdata, prdata, pready)
// holds ham_mode at 0x0 and transparent_zero at 0x4; pready is always high.
// synchronous reset (rst_n low) clears both registers, the held colour and
// the per-entry valid bits, so every palette entry reads as zero until
// written; no clearing pass is needed.
// when out_if stalls the decoded pixel waits in the output register, one
// more pixel waits in the read stage, and in_if.ready drops after that.
module ham_ehb_pixel_colour (
  input  logic                        clk,
  input  logic                        rst_n,
  hepc_in_if.sink                     in_if,
  hepc_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hepc_pkg::CFG_AW-1:0] paddr,
  input  logic [hepc_pkg::CFG_DW-1:0] pwdata,
  output logic [hepc_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import hepc_pkg::*;

  logic                    ham_mode_r;
  logic                    trans_zero_r;
  logic                    cfg_wr;

  logic                    in_xfer;
  logic                    pal_we;
  logic                    pix_take;
  logic [IDX_W-1:0]        rd_idx;
  logic                    rd_in_range;
  logic                    wr_in_range;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [WORD_W-1:0]       ram_rdata;

  logic                    s1_valid_r;
  logic                    s1_line_r;
  logic [PIX_W-1:0]        s1_pix_r;
  logic                    s1_ok_r;
  logic                    s1_adv;

  nib_t                    held_red_r, held_green_r, held_blue_r;
  nib_t                    held_red_nxt, held_green_nxt, held_blue_nxt;
  nib_t                    base_red, base_green, base_blue;
  logic [WORD_W-1:0]       colour;
  chan_t                   red_nxt, green_nxt, blue_nxt;
  logic                    trans_nxt;

  logic                    out_valid_r;
  chan_t                   out_red_r, out_green_r, out_blue_r;
  logic                    out_trans_r;

  // apb configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ham_mode_r   <= 1'b0;
      trans_zero_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_HAM_MODE:   ham_mode_r   <= pwdata[0];
        REG_TRANS_ZERO: trans_zero_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_HAM_MODE:   prdata[0] = ham_mode_r;
      REG_TRANS_ZERO: prdata[0] = trans_zero_r;
      default: ;
    endcase
  end

  // input side and palette ram
  assign s1_adv       = !out_valid_r || out_if.ready;
  assign in_if.ready  = !s1_valid_r || s1_adv;
  assign in_xfer      = in_if.valid && in_if.ready;
  assign wr_in_range  = int'(in_if.palette_index) < TABLE_ENTRIES;
  assign pal_we       = in_xfer && (in_if.op == OP_PAL_WRITE) && wr_in_range;
  assign pix_take     = in_xfer && (in_if.op == OP_PIXEL);
  assign rd_idx       = ham_mode_r ? {1'b0, in_if.pixel_value[NIB_W-1:0]}
                                   : in_if.pixel_value[IDX_W-1:0];
  assign rd_in_range  = int'(rd_idx) < TABLE_ENTRIES;

  hepc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_if.palette_index[TBL_AW-1:0]),
    .wdata (in_if.palette_word),
    .re    (pix_take),
    .raddr (rd_idx[TBL_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (pal_we) begin
      valid_r[in_if.palette_index[TBL_AW-1:0]] <= 1'b1;
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= pix_take;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) begin
      s1_line_r <= in_if.line_start;
      s1_pix_r  <= in_if.pixel_value;
      s1_ok_r   <= rd_in_range && valid_r[rd_idx[TBL_AW-1:0]];
    end
  end

  // decode
  assign colour     = s1_ok_r ? ram_rdata : '0;
  assign base_red   = s1_line_r ? '0 : held_red_r;
  assign base_green = s1_line_r ? '0 : held_green_r;
  assign base_blue  = s1_line_r ? '0 : held_blue_r;

  always_comb begin
    held_red_nxt   = base_red;
    held_green_nxt = base_green;
    held_blue_nxt  = base_blue;
    red_nxt        = '0;
    green_nxt      = '0;
    blue_nxt       = '0;
    trans_nxt      = 1'b0;
    if (ham_mode_r) begin
      unique case (s1_pix_r[PIX_W-1:NIB_W])
        HAM_BASE: begin
          held_red_nxt   = colour[11:8];
          held_green_nxt = colour[7:4];
          held_blue_nxt  = colour[3:0];
        end
        HAM_BLUE:  held_blue_nxt  = s1_pix_r[NIB_W-1:0];
        HAM_RED:   held_red_nxt   = s1_pix_r[NIB_W-1:0];
        HAM_GREEN: held_green_nxt = s1_pix_r[NIB_W-1:0];
        default: ;
      endcase
      red_nxt   = widen(held_red_nxt);
      green_nxt = widen(held_green_nxt);
      blue_nxt  = widen(held_blue_nxt);
    end else begin
      red_nxt   = widen(colour[11:8]);
      green_nxt = widen(colour[7:4]);
      blue_nxt  = widen(colour[3:0]);
      if (s1_pix_r[PIX_W-1]) begin
        red_nxt   = red_nxt >> 1;
        green_nxt = green_nxt >> 1;
        blue_nxt  = blue_nxt >> 1;
      end
      trans_nxt = trans_zero_r && (s1_pix_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_red_r   <= '0;
      held_green_r <= '0;
      held_blue_r  <= '0;
    end else if (s1_valid_r && s1_adv) begin
      held_red_r   <= held_red_nxt;
      held_green_r <= held_green_nxt;
      held_blue_r  <= held_blue_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
      out_blue_r  <= blue_nxt;
      out_trans_r <= trans_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.red            = out_red_r;
  assign out_if.green          = out_green_r;
  assign out_if.blue           = out_blue_r;
  assign out_if.is_transparent = out_trans_r;

endmodule

// File: verif/tb_top.sv
// testbench for ham_ehb_pixel_colour: directed and random pixel streams with self-checking
`timescale 1ns / 1ps

module tb_top;
  import hepc_pkg::*;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  transparent;
  } colour_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  hepc_in_if  in_ch ();
  hepc_out_if out_ch ();

  ham_ehb_pixel_colour uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // shadow of the block state
  logic [WORD_W-1:0] palette_shadow [TABLE_ENTRIES];
  nib_t              held_r;
  nib_t              held_g;
  nib_t              held_b;
  logic              ham_on;
  logic              zero_is_clear;

  colour_t pending_colours [$];
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_off_cycles = 0;

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_PIXEL;
    in_ch.line_start = 1'b0;
    in_ch.pixel_value = '0;
    in_ch.palette_index = '0;
    in_ch.palette_word = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) palette_shadow[i] = '0;
    held_r = '0;
    held_g = '0;
    held_b = '0;
    ham_on = 1'b0;
    zero_is_clear = 1'b0;
  end

  function automatic chan_t nib_to_chan(input nib_t n);
    return chan_t'(n) * chan_t'(17);
  endfunction

  function automatic logic [WORD_W-1:0] palette_lookup(input int idx);
    return (idx < TABLE_ENTRIES) ? palette_shadow[idx] : '0;
  endfunction

  // updates the shadow state and queues the colour a pixel should produce
  function automatic void colour_item(input logic op, input logic ls,
                                     input logic [PIX_W-1:0] pix,
                                     input logic [IDX_W-1:0] idx,
                                     input logic [WORD_W-1:0] word);
    colour_t           c;
    logic [WORD_W-1:0] entry;
    if (op == OP_PAL_WRITE) begin
      if (idx < TABLE_ENTRIES) palette_shadow[idx] = word;
      return;
    end
    if (ls) begin
      held_r = '0;
      held_g = '0;
      held_b = '0;
    end
    if (ham_on) begin
      case (pix[5:4])
        HAM_BASE: begin
          entry = palette_lookup(pix[3:0]);
          held_r = entry[11:8];
          held_g = entry[7:4];
          held_b = entry[3:0];
        end
        HAM_BLUE:  held_b = pix[3:0];
        HAM_RED:   held_r = pix[3:0];
        default:   held_g = pix[3:0];
      endcase
      c.red = nib_to_chan(held_r);
      c.green = nib_to_chan(held_g);
      c.blue = nib_to_chan(held_b);
      c.transparent = 1'b0;
    end else begin
      entry = palette_lookup(pix[4:0]);
      c.red = nib_to_chan(entry[11:8]);
      c.green = nib_to_chan(entry[7:4]);
      c.blue = nib_to_chan(entry[3:0]);
      if (pix[5]) begin
        c.red = c.red >> 1;
        c.green = c.green >> 1;
        c.blue = c.blue >> 1;
      end
      c.transparent = (pix == '0) && zero_is_clear;
    end
    pending_colours.push_back(c);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      colour_item(in_ch.op, in_ch.line_start, in_ch.pixel_value, in_ch.palette_index,
                  in_ch.palette_word);
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    colour_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_colours.size() == 0) begin
        $display("%0t unexpected transfer expected none actual r=%0d g=%0d b=%0d t=%0d",
                 $time, out_ch.red, out_ch.green, out_ch.blue, out_ch.is_transparent);
        mismatches++;
      end else begin
        want = pending_colours.pop_front();
        check_field("red", want.red, out_ch.red);
        check_field("green", want.green, out_ch.green);
        check_field("blue", want.blue, out_ch.blue);
        check_field("is_transparent", want.transparent, out_ch.is_transparent);
      end
    end
  end

  // output side: random stalls plus an optional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic op, input logic ls, input logic [PIX_W-1:0] pix,
                           input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.line_start <= ls;
    in_ch.pixel_value <= pix;
    in_ch.palette_index <= idx;
    in_ch.palette_word <= word;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_pixel(input logic ls, input logic [PIX_W-1:0] pix);
    send_item(OP_PIXEL, ls, pix, IDX_W'($urandom), WORD_W'($urandom));
  endtask

  task automatic send_palette(input logic ls, input logic [IDX_W-1:0] idx,
                              input logic [WORD_W-1:0] word);
    send_item(OP_PAL_WRITE, ls, PIX_W'($urandom), idx, word);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic reg_idx, input logic val);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= CFG_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      REG_HAM_MODE: ham_on = val;
      REG_TRANS_ZERO: zero_is_clear = val;
    endcase
  endtask

  task automatic test_indexed_directed;
    send_pixel(1'b1, 6'd0);
    send_pixel(1'b0, 6'd63);
    send_palette(1'b1, 5'd0, 12'hFFF);
    send_palette(1'b0, 5'd31, 12'hA5C);
    send_palette(1'b0, 5'd16, 12'h0F0);
    send_pixel(1'b0, 6'd0);
    send_pixel(1'b0, 6'd31);
    send_pixel(1'b0, 6'd32);
    send_pixel(1'b0, 6'd63);
    send_pixel(1'b0, 6'd48);
    cfg_write(REG_TRANS_ZERO, 1'b1);
    send_pixel(1'b0, 6'd0);
    send_pixel(1'b0, 6'd32);
    send_pixel(1'b1, 6'd31);
  endtask

  task automatic test_ham_directed;
    cfg_write(REG_HAM_MODE, 1'b1);
    send_pixel(1'b1, {HAM_BASE, 4'h0});
    send_pixel(1'b0, {HAM_BLUE, 4'h0});
    send_pixel(1'b0, {HAM_RED, 4'h3});
    send_pixel(1'b0, {HAM_GREEN, 4'hF});
    send_pixel(1'b1, 6'd0);
    send_pixel(1'b0, {HAM_BASE, 4'hF});
    send_pixel(1'b1, {HAM_BLUE, 4'hF});
    send_pixel(1'b0, {HAM_RED, 4'hF});
    // line start in indexed mode must still clear the held colour
    cfg_write(REG_HAM_MODE, 1'b0);
    cfg_write(REG_TRANS_ZERO, 1'b0);
    send_pixel(1'b1, 6'd5);
    cfg_write(REG_HAM_MODE, 1'b1);
    send_pixel(1'b0, {HAM_GREEN, 4'h1});
  endtask

  task automatic test_random_stream(input int per_setting);
    int sent;
    int kind;
    int len;
    int first;
    logic [1:0] combo;
    logic [PIX_W-1:0] pix;
    first = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      combo = 2'(first + k);
      cfg_write(REG_HAM_MODE, combo[0]);
      cfg_write(REG_TRANS_ZERO, combo[1]);
      sent = 0;
      while (sent < per_setting) begin
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
          len = $urandom_range(1, 12);
          for (int p = 0; p < len; p++) begin
            if ($urandom_range(0, 9) == 0) begin
              send_palette(1'($urandom), IDX_W'($urandom), WORD_W'($urandom));
              sent++;
            end
            pix = ($urandom_range(0, 9) == 0) ? '0 : PIX_W'($urandom);
            send_pixel(p == 0, pix);
            sent++;
          end
        end else if (kind < 90) begin
          len = $urandom_range(1, 4);
          for (int p = 0; p < len; p++) begin
            send_palette(1'($urandom), IDX_W'($urandom), WORD_W'($urandom));
            sent++;
          end
        end else begin
          send_item(1'($urandom), 1'($urandom), PIX_W'($urandom), IDX_W'($urandom),
                    WORD_W'($urandom));
          sent++;
        end
      end
    end
  endtask

  task automatic test_output_stall;
    int saved_idle;
    saved_idle = send_idle_pct;
    send_idle_pct = 0;
    hold_off_cycles = 40;
    for (int p = 0; p < 16; p++) send_pixel(p == 0, PIX_W'($urandom));
    send_idle_pct = saved_idle;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 28;
    recv_idle_pct = 72;
    test_indexed_directed();
    test_ham_directed();
    test_random_stream(50);
    send_idle_pct = 72;
    recv_idle_pct = 28;
    test_random_stream(50);
    test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(50);
    drain();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("ham_ehb_pixel_colour verification clean");
    end else begin
      $display("ham_ehb_pixel_colour verification failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("ham_ehb_pixel_colour verification failed");
    $finish;
  end

endmodule
